// ===== rtl/lphm_pkg.sv =====
// shared types, codes and hash constants for the linear probe hash map
package lphm_pkg;

  typedef logic [1:0]  action_t;
  typedef logic [1:0]  status_t;
  typedef logic [31:0] hash_t;

  localparam action_t ACT_GET  = 2'd0;
  localparam action_t ACT_PUT  = 2'd1;
  localparam action_t ACT_DEL  = 2'd2;
  localparam action_t ACT_NONE = 2'd3;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_OVERWRITE = 2'd1;
  localparam status_t ST_ABSENT    = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

  localparam hash_t FNV_OFFSET = 32'h811C_9DC5;
  localparam hash_t FNV_PRIME  = 32'h0100_0193;

  localparam int LOAD_NUM   = 3;
  localparam int LOAD_DEN   = 4;
  localparam int SLOT_BITS  = 8;
  localparam int COUNT_BITS = 9;

  typedef struct packed {
    logic used;
    logic tomb;
  } flags_t;

  typedef struct packed {
    logic busy;
    logic done;
  } hash_stat_t;

  function automatic hash_t fnv1a_step(hash_t h, logic [7:0] b);
    hash_t x;
    x = h ^ {24'd0, b};
    return x * FNV_PRIME;
  endfunction

endpackage

// ===== rtl/linear_probe_hash_map_unit.sv =====
// linear probe hash map: open-addressing key/value table with tombstones
//
// in channel carries one get, put or delete beat (action, key, value);
// out channel returns one beat per item (status, read_value, slot,
// entry_count). both use valid/stall, a beat moves when valid and not stall.
// the key is hashed one byte a cycle (fnv-1a), then the probe reads one slot
// a cycle from the slot memory, then the apply step applies the result and
// writes the slot back. the probe stops at a match or an empty slot, so it
// reads one slot at low load and at most TABLE_DEPTH slots; a new beat can
// be taken in the cycle that output valid rises. the unused action code
// skips hash and probe and goes straight to the apply step.
// one item is in flight at a time; the output register frees the input side,
// so a new beat is accepted while a result waits, and the apply step holds
// off while the out side stalls with a result still pending.
// after reset in_stall stays high while the slot memory flags are swept
// clear; counters reset to zero.
module linear_probe_hash_map_unit #(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lphm_pkg::action_t                 in_action,
  input  logic [KEY_BITS-1:0]               in_key,
  input  logic [VALUE_BITS-1:0]             in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lphm_pkg::status_t                 out_status,
  output logic [VALUE_BITS-1:0]             out_read_value,
  output logic [lphm_pkg::SLOT_BITS-1:0]    out_slot,
  output logic [lphm_pkg::COUNT_BITS-1:0]   out_entry_count
);
  import lphm_pkg::*;

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int LIM_W = CW + 3;
  localparam logic [LIM_W-1:0] LOAD_LIMIT = LIM_W'(LOAD_NUM * TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_ISSUE,
    S_PROBE,
    S_APPLY
  } state_t;

  state_t                state_r;
  action_t               act_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [AW-1:0]         slot_r;
  logic [AW-1:0]         home_r;
  logic [AW-1:0]         tomb_slot_r;
  logic                  have_tomb_r;
  logic [AW-1:0]         step_r;
  logic [AW-1:0]         end_slot_r;
  logic                  end_tomb_r;
  logic                  hit_r;
  logic [VALUE_BITS-1:0] found_r;
  logic [CW-1:0]         live_r;
  logic [CW-1:0]         filled_r;

  logic                  out_valid_r;
  status_t               out_status_r;
  logic [VALUE_BITS-1:0] out_value_r;
  logic [SLOT_BITS-1:0]  out_slot_r;
  logic [COUNT_BITS-1:0] out_count_r;

  hash_t                 hash;
  hash_stat_t            hstat;
  logic                  in_take;
  logic                  clr_busy;

  logic [AW-1:0]         rd_addr;
  flags_t                rd_flags;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_value;

  logic                  wr_en;
  flags_t                wr_flags;
  logic [VALUE_BITS-1:0] wr_value;

  status_t               status_nxt;
  logic [VALUE_BITS-1:0] rv_nxt;
  logic [CW-1:0]         live_nxt;
  logic [CW-1:0]         filled_nxt;
  logic                  full;
  logic                  apply_go;

  logic                  p_empty;
  logic                  p_match;
  logic                  p_tomb;
  logic                  p_last;
  logic                  have_tomb_nxt;
  logic [AW-1:0]         tomb_slot_nxt;

  logic [CW+SLOT_BITS-1:0]  slot_ext;
  logic [CW+COUNT_BITS-1:0] count_ext;

  assign in_stall  = clr_busy || (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign apply_go  = (state_r == S_APPLY) && (!out_valid_r || !out_stall);

  lphm_hash #(
    .KEY_BITS (KEY_BITS)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_take && (in_action != ACT_NONE)),
    .key   (in_key),
    .hash  (hash),
    .stat  (hstat)
  );

  assign rd_addr = (state_r == S_ISSUE) ? hash[AW-1:0] : slot_r + 1'b1;

  lphm_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS),
    .AW          (AW)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (rd_addr),
    .rd_flags (rd_flags),
    .rd_key   (rd_key),
    .rd_value (rd_value),
    .wr_en    (wr_en),
    .wr_addr  (end_slot_r),
    .wr_flags (wr_flags),
    .wr_key   (key_r),
    .wr_value (wr_value),
    .clr_busy (clr_busy)
  );

  // probe step on the slot read last cycle
  always_comb begin
    p_empty       = !rd_flags.used && !rd_flags.tomb;
    p_tomb        = !rd_flags.used && rd_flags.tomb;
    p_match       = rd_flags.used && (rd_key == key_r);
    p_last        = (step_r == AW'(TABLE_DEPTH - 1));
    have_tomb_nxt = have_tomb_r || p_tomb;
    tomb_slot_nxt = (p_tomb && !have_tomb_r) ? slot_r : tomb_slot_r;
  end

  assign full = ((LIM_W'(filled_r) + 1'b1) * LIM_W'(LOAD_DEN)) > LOAD_LIMIT;

  always_comb begin
    status_nxt = ST_ABSENT;
    rv_nxt     = '0;
    live_nxt   = live_r;
    filled_nxt = filled_r;
    wr_en      = 1'b0;
    wr_flags   = '{used: 1'b1, tomb: 1'b0};
    wr_value   = val_r;
    unique case (act_r)
      ACT_GET: begin
        if (hit_r) begin
          status_nxt = ST_OK;
          rv_nxt     = found_r;
        end
      end
      ACT_PUT: begin
        if (hit_r) begin
          status_nxt = ST_OVERWRITE;
          wr_en      = 1'b1;
        end else if (!end_tomb_r && full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_OK;
          wr_en      = 1'b1;
          live_nxt   = live_r + 1'b1;
          if (!end_tomb_r) begin
            filled_nxt = filled_r + 1'b1;
          end
        end
      end
      ACT_DEL: begin
        if (hit_r) begin
          status_nxt = ST_OK;
          wr_en      = 1'b1;
          wr_flags   = '{used: 1'b0, tomb: 1'b1};
          wr_value   = found_r;
          live_nxt   = live_r - 1'b1;
        end
      end
      ACT_NONE: begin
        status_nxt = ST_ABSENT;
      end
      default: begin
        status_nxt = ST_ABSENT;
      end
    endcase
    wr_en = wr_en && apply_go;
  end

  assign slot_ext  = (act_r == ACT_NONE) ? '0 : (CW + SLOT_BITS)'(end_slot_r);
  assign count_ext = (CW + COUNT_BITS)'(live_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      live_r      <= '0;
      filled_r    <= '0;
    end else begin
      if (out_valid_r && !out_stall && !apply_go) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            act_r <= in_action;
            key_r <= in_key;
            val_r <= in_value;
            hit_r <= 1'b0;
            state_r <= (in_action == ACT_NONE) ? S_APPLY : S_HASH;
          end
        end
        S_HASH: begin
          if (hstat.done) begin
            state_r <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          slot_r      <= hash[AW-1:0];
          home_r      <= hash[AW-1:0];
          step_r      <= '0;
          have_tomb_r <= 1'b0;
          hit_r       <= 1'b0;
          state_r     <= S_PROBE;
        end
        S_PROBE: begin
          have_tomb_r <= have_tomb_nxt;
          tomb_slot_r <= tomb_slot_nxt;
          if (p_match) begin
            hit_r      <= 1'b1;
            end_slot_r <= slot_r;
            end_tomb_r <= 1'b0;
            found_r    <= rd_value;
            state_r    <= S_APPLY;
          end else if (p_empty) begin
            end_slot_r <= have_tomb_r ? tomb_slot_r : slot_r;
            end_tomb_r <= have_tomb_r;
            state_r    <= S_APPLY;
          end else if (p_last) begin
            end_slot_r <= have_tomb_nxt ? tomb_slot_nxt : home_r;
            end_tomb_r <= have_tomb_nxt;
            state_r    <= S_APPLY;
          end else begin
            slot_r <= slot_r + 1'b1;
            step_r <= step_r + 1'b1;
          end
        end
        S_APPLY: begin
          if (apply_go) begin
            live_r       <= live_nxt;
            filled_r     <= filled_nxt;
            out_valid_r  <= 1'b1;
            out_status_r <= status_nxt;
            out_value_r  <= rv_nxt;
            out_slot_r   <= slot_ext[SLOT_BITS-1:0];
            out_count_r  <= count_ext[COUNT_BITS-1:0];
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_value_r;
  assign out_slot        = out_slot_r;
  assign out_entry_count = out_count_r;

`ifndef SYNTHESIS
  a_live_le_filled: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= filled_r)
    else $error("live entries exceed filled slots");

  a_load_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (LIM_W'(filled_r) * LIM_W'(LOAD_DEN)) <= LOAD_LIMIT)
    else $error("filled slots beyond load limit");

  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == S_HASH || state_r == S_APPLY))
    else $error("accepted beat did not start hashing or apply");

  a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> (!wr_en && state_r == S_IDLE))
    else $error("table access during clearing sweep");

  a_hash_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !hstat.busy)
    else $error("hash engine busy while idle");
`endif

endmodule

// ===== rtl/lphm_hash.sv =====
// iterative fnv-1a hash, one key byte per cycle
module lphm_hash #(
  parameter int KEY_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [KEY_BITS-1:0]   key,
  output lphm_pkg::hash_t       hash,
  output lphm_pkg::hash_stat_t  stat
);
  import lphm_pkg::*;

  localparam int KEY_BYTES = (KEY_BITS + 7) / 8;
  localparam int KEY_PAD   = KEY_BYTES * 8;
  localparam int CNT_W     = $clog2(KEY_BYTES + 1);

  logic [KEY_PAD-1:0] key_r;
  logic [CNT_W-1:0]   cnt_r;
  hash_t              h_r;
  logic               busy_r;
  logic               done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        h_r    <= FNV_OFFSET;
        key_r  <= KEY_PAD'(key);
      end else if (busy_r) begin
        h_r   <= fnv1a_step(h_r, key_r[7:0]);
        key_r <= key_r >> 8;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(KEY_BYTES - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign hash      = h_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== rtl/lphm_mem.sv =====
// slot memory with flags, key and value, cleared by a sweep after reset
module lphm_mem #(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32,
  parameter int AW          = $clog2(TABLE_DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [AW-1:0]          rd_addr,
  output lphm_pkg::flags_t       rd_flags,
  output logic [KEY_BITS-1:0]    rd_key,
  output logic [VALUE_BITS-1:0]  rd_value,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  lphm_pkg::flags_t       wr_flags,
  input  logic [KEY_BITS-1:0]    wr_key,
  input  logic [VALUE_BITS-1:0]  wr_value,
  output logic                   clr_busy
);
  import lphm_pkg::*;

  localparam int W = $bits(flags_t) + KEY_BITS + VALUE_BITS;

  logic [W-1:0]  mem [TABLE_DEPTH];
  logic [W-1:0]  rd_q;
  logic          clr_r;
  logic [AW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(TABLE_DEPTH - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= {wr_flags, wr_key, wr_value};
    end
    rd_q <= mem[rd_addr];
  end

  assign {rd_flags, rd_key, rd_value} = rd_q;
  assign clr_busy = clr_r;

endmodule
